FILE: rtl/core/duty_cycled_sensor_sampler_unit_assert.svh
// Assertion macros for the duty-cycled sensor sampler.
// Needs clk and arst_n in the scope of each use.
`ifndef DUTY_CYCLED_SENSOR_SAMPLER_UNIT_ASSERT_SVH
`define DUTY_CYCLED_SENSOR_SAMPLER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DCSS_ASSERT_NOW(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
`define DCSS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define DCSS_ASSERT_NOW(label, expr, msg)
`define DCSS_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: rtl/core/dcss_pkg.sv
// Shared types and constants of the duty-cycled sensor sampler.
// No dependencies.
package dcss_pkg;

	localparam int ADC_BITS_DEF  = 12;
	localparam int TICK_BITS_DEF = 32;
	localparam int SUM_BITS      = 32;
	localparam int CNT_BITS      = 16;
	localparam int AVG_BITS      = 16;
	localparam int WARN_BITS     = 8;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_BITS      = 16;
	localparam int DIV_STEPS     = 32;

	localparam logic [WARN_BITS-1:0] WARN_LIMIT = 8'd2;

	typedef enum logic [2:0] {
		PH_SLEEP   = 3'd0,
		PH_SETUP   = 3'd1,
		PH_MEASURE = 3'd2,
		PH_PROCESS = 3'd3,
		PH_WARNING = 3'd4,
		PH_SAVING  = 3'd5
	} phase_t;

	// Register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_THR_LOW  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_THR_HIGH = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_THR_MAX  = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_SETUP    = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_WARNING  = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_SLEEP    = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_MEASURE  = 3'd6;
	localparam logic [CFG_IDX_BITS-1:0] REG_SAMPLES  = 3'd7;

	// Register reset values
	localparam logic [CFG_BITS-1:0] RST_THR_LOW  = 16'd0;
	localparam logic [CFG_BITS-1:0] RST_THR_HIGH = 16'hFFFF;
	localparam logic [CFG_BITS-1:0] RST_THR_MAX  = 16'd4095;
	localparam logic [CFG_BITS-1:0] RST_PERIOD   = 16'd0;
	localparam logic [CFG_BITS-1:0] RST_SAMPLES  = 16'd1;

endpackage

FILE: rtl/core/duty_cycled_sensor_sampler_unit.sv
// Duty-cycled sensor sampler: one transaction in per millisecond tick, one result out.
// Each tick passes the compare, execute and finish states, plus a deadline state when a
// deadline is set, or the divide (32-step restoring divider) and average states when the
// average is computed; a new tick is taken only in idle, and finish stalls on the result register.
// One shared adder serves accumulation, deadlines and the tick; needs dcss_pkg and the assert header.
// Asynchronous active-low reset returns phase, tick, deadlines, config and flags to defaults.
`include "duty_cycled_sensor_sampler_unit_assert.svh"

module duty_cycled_sensor_sampler_unit #(
	parameter int ADC_BITS  = dcss_pkg::ADC_BITS_DEF,
	parameter int TICK_BITS = dcss_pkg::TICK_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [ADC_BITS-1:0]                  adc_sample,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [2:0]                           phase,
	output logic                                 supply_on,
	output logic                                 record_valid,
	output logic                                 record_alarm,
	output logic                                 record_error,
	output logic [dcss_pkg::AVG_BITS-1:0]        record_average,
	output logic                                 error_flag,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [dcss_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [dcss_pkg::CFG_BITS-1:0]        cfg_data
);

	localparam int SB  = dcss_pkg::SUM_BITS;
	localparam int CB  = dcss_pkg::CNT_BITS;
	localparam int AB  = dcss_pkg::AVG_BITS;
	localparam int WB  = dcss_pkg::WARN_BITS;
	localparam int DCB = $clog2(dcss_pkg::DIV_STEPS);

	typedef enum logic [2:0] {
		ST_IDLE, ST_CMP, ST_EXEC, ST_DL, ST_DIV, ST_AVG, ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		DL_SLEEP, DL_SETUP, DL_MEASURE, DL_WARNING
	} dl_sel_t;

	// Configuration
	logic [dcss_pkg::CFG_BITS-1:0] thr_low_q, thr_high_q, thr_max_q;
	logic [dcss_pkg::CFG_BITS-1:0] setup_per_q, warn_per_q, sleep_per_q, meas_per_q;
	logic [dcss_pkg::CFG_BITS-1:0] samples_q;

	// Sequencer and model state
	state_t                 state_q;
	dl_sel_t                dl_sel_q;
	dcss_pkg::phase_t       phase_q;
	logic [TICK_BITS-1:0]   tick_q;
	logic [TICK_BITS-1:0]   dl_sleep_q, dl_setup_q, dl_meas_q, dl_warn_q;
	logic [SB-1:0]          sum_q;
	logic [CB-1:0]          count_q;
	logic [AB-1:0]          avg_q;
	logic [WB-1:0]          warn_q;
	logic                   alarm_q, error_q, power_q, saved_q, gt_q;
	logic [ADC_BITS-1:0]    sample_q;

	// Divider
	logic [CB:0]            rem_q;
	logic [SB-1:0]          dq_q;
	logic [DCB-1:0]         div_cnt_q;

	// Output register
	logic                   out_valid_q;
	dcss_pkg::phase_t       out_phase_q;
	logic                   out_supply_q, out_rec_q, out_alarm_q, out_err_q, out_flag_q;
	logic [AB-1:0]          out_avg_q;

	// Shared adder
	logic [SB:0]            add_a, add_b, add_res;
	logic [TICK_BITS-1:0]   dl_cmp;
	logic [CB-1:0]          period_sel;
	logic [CB:0]            div_shift, div_diff;
	logic [AB-1:0]          avg_new;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;

	always_comb begin
		unique case (dl_sel_q)
			DL_SLEEP:   period_sel = sleep_per_q;
			DL_SETUP:   period_sel = setup_per_q;
			DL_MEASURE: period_sel = meas_per_q;
			DL_WARNING: period_sel = warn_per_q;
		endcase
	end

	always_comb begin
		unique case (state_q)
			ST_EXEC: begin
				add_a = {1'b0, sum_q};
				add_b = {{(SB + 1 - ADC_BITS){1'b0}}, sample_q};
			end
			ST_DL: begin
				add_a = {{(SB + 1 - TICK_BITS){1'b0}}, tick_q};
				add_b = {{(SB + 1 - CB){1'b0}}, period_sel};
			end
			default: begin
				add_a = {{(SB + 1 - TICK_BITS){1'b0}}, tick_q};
				add_b = (SB + 1)'(1);
			end
		endcase
	end
	assign add_res = add_a + add_b;

	always_comb begin
		unique case (phase_q)
			dcss_pkg::PH_SLEEP:   dl_cmp = dl_sleep_q;
			dcss_pkg::PH_SETUP:   dl_cmp = dl_setup_q;
			dcss_pkg::PH_MEASURE: dl_cmp = dl_meas_q;
			dcss_pkg::PH_WARNING: dl_cmp = dl_warn_q;
			default:              dl_cmp = '0;
		endcase
	end

	assign div_shift = {rem_q[CB-1:0], dq_q[SB-1]};
	assign div_diff  = div_shift - {1'b0, count_q};
	// Saturate a quotient wider than the average; a zero count averages to zero
	assign avg_new = (count_q == '0) ? '0 :
		((dq_q[SB-1:AB] != '0) ? '1 : dq_q[AB-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_low_q   <= dcss_pkg::RST_THR_LOW;
			thr_high_q  <= dcss_pkg::RST_THR_HIGH;
			thr_max_q   <= dcss_pkg::RST_THR_MAX;
			setup_per_q <= dcss_pkg::RST_PERIOD;
			warn_per_q  <= dcss_pkg::RST_PERIOD;
			sleep_per_q <= dcss_pkg::RST_PERIOD;
			meas_per_q  <= dcss_pkg::RST_PERIOD;
			samples_q   <= dcss_pkg::RST_SAMPLES;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				dcss_pkg::REG_THR_LOW:  thr_low_q   <= cfg_data;
				dcss_pkg::REG_THR_HIGH: thr_high_q  <= cfg_data;
				dcss_pkg::REG_THR_MAX:  thr_max_q   <= cfg_data;
				dcss_pkg::REG_SETUP:    setup_per_q <= cfg_data;
				dcss_pkg::REG_WARNING:  warn_per_q  <= cfg_data;
				dcss_pkg::REG_SLEEP:    sleep_per_q <= cfg_data;
				dcss_pkg::REG_MEASURE:  meas_per_q  <= cfg_data;
				dcss_pkg::REG_SAMPLES:  samples_q   <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			dl_sel_q     <= DL_SLEEP;
			phase_q      <= dcss_pkg::PH_SLEEP;
			tick_q       <= '0;
			dl_sleep_q   <= '0;
			dl_setup_q   <= '0;
			dl_meas_q    <= '0;
			dl_warn_q    <= '0;
			sum_q        <= '0;
			count_q      <= '0;
			avg_q        <= '0;
			warn_q       <= '0;
			alarm_q      <= 1'b0;
			error_q      <= 1'b0;
			power_q      <= 1'b0;
			saved_q      <= 1'b0;
			gt_q         <= 1'b0;
			div_cnt_q    <= '0;
			out_valid_q  <= 1'b0;
			out_phase_q  <= dcss_pkg::PH_SLEEP;
			out_supply_q <= 1'b0;
			out_rec_q    <= 1'b0;
			out_alarm_q  <= 1'b0;
			out_err_q    <= 1'b0;
			out_flag_q   <= 1'b0;
			out_avg_q    <= '0;
		end else begin
			// drop the result once taken; the final step refills it itself
			if (out_valid_q && out_ready && state_q != ST_FIN) out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						sample_q <= adc_sample;
						saved_q  <= 1'b0;
						state_q  <= ST_CMP;
					end
				end
				ST_CMP: begin
					gt_q    <= (tick_q > dl_cmp);
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q <= ST_FIN;
					unique case (phase_q)
						dcss_pkg::PH_SLEEP: begin
							if (gt_q) begin
								sum_q    <= '0;
								count_q  <= '0;
								avg_q    <= '0;
								warn_q   <= '0;
								error_q  <= 1'b0;
								power_q  <= 1'b1;
								phase_q  <= dcss_pkg::PH_SETUP;
								dl_sel_q <= DL_SETUP;
								state_q  <= ST_DL;
							end
						end
						dcss_pkg::PH_SETUP, dcss_pkg::PH_MEASURE,
						dcss_pkg::PH_WARNING: begin
							if (gt_q) begin
								// take a sample, saturating sum and count
								sum_q <= add_res[SB] ? '1 : add_res[SB-1:0];
								if (count_q != '1) count_q <= count_q + CB'(1);
								phase_q  <= dcss_pkg::PH_MEASURE;
								dl_sel_q <= DL_MEASURE;
								state_q  <= ST_DL;
							end else if (phase_q == dcss_pkg::PH_MEASURE &&
									count_q >= samples_q) begin
								rem_q     <= '0;
								dq_q      <= sum_q;
								div_cnt_q <= '0;
								state_q   <= ST_DIV;
							end else if (phase_q == dcss_pkg::PH_WARNING &&
									warn_q >= dcss_pkg::WARN_LIMIT) begin
								saved_q <= 1'b1;
								phase_q <= dcss_pkg::PH_SAVING;
							end
						end
						dcss_pkg::PH_PROCESS: begin
							if (avg_q == '0 || avg_q > thr_max_q) begin
								if (warn_q != '1) warn_q <= warn_q + WB'(1);
								phase_q  <= dcss_pkg::PH_WARNING;
								dl_sel_q <= DL_WARNING;
								state_q  <= ST_DL;
							end else begin
								saved_q <= 1'b1;
								phase_q <= dcss_pkg::PH_SAVING;
							end
						end
						dcss_pkg::PH_SAVING: begin
							power_q <= 1'b0;
							if (warn_q >= dcss_pkg::WARN_LIMIT) error_q <= 1'b1;
							phase_q  <= dcss_pkg::PH_SLEEP;
							dl_sel_q <= DL_SLEEP;
							state_q  <= ST_DL;
						end
						default: phase_q <= dcss_pkg::PH_SLEEP;
					endcase
				end
				ST_DL: begin
					unique case (dl_sel_q)
						DL_SLEEP:   dl_sleep_q <= add_res[TICK_BITS-1:0];
						DL_SETUP:   dl_setup_q <= add_res[TICK_BITS-1:0];
						DL_MEASURE: dl_meas_q  <= add_res[TICK_BITS-1:0];
						DL_WARNING: dl_warn_q  <= add_res[TICK_BITS-1:0];
					endcase
					state_q <= ST_FIN;
				end
				ST_DIV: begin
					// one restoring step: shift in the next dividend bit
					if (!div_diff[CB]) begin
						rem_q <= div_diff;
						dq_q  <= {dq_q[SB-2:0], 1'b1};
					end else begin
						rem_q <= div_shift;
						dq_q  <= {dq_q[SB-2:0], 1'b0};
					end
					div_cnt_q <= div_cnt_q + DCB'(1);
					if (div_cnt_q == DCB'(dcss_pkg::DIV_STEPS - 1)) state_q <= ST_AVG;
				end
				ST_AVG: begin
					avg_q   <= avg_new;
					alarm_q <= !(avg_new <= thr_high_q && avg_new >= thr_low_q);
					phase_q <= dcss_pkg::PH_PROCESS;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					// hold until the output register is free
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						out_phase_q  <= phase_q;
						out_supply_q <= power_q;
						out_rec_q    <= saved_q;
						out_alarm_q  <= saved_q && alarm_q;
						out_err_q    <= saved_q && error_q;
						out_avg_q    <= saved_q ? avg_q : '0;
						out_flag_q   <= error_q;
						tick_q       <= add_res[TICK_BITS-1:0];
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign phase          = out_phase_q;
	assign supply_on      = out_supply_q;
	assign record_valid   = out_rec_q;
	assign record_alarm   = out_alarm_q;
	assign record_error   = out_err_q;
	assign record_average = out_avg_q;
	assign error_flag     = out_flag_q;

	`DCSS_ASSERT_NOW(a_record_in_saving,
		!(out_valid && record_valid) || phase == dcss_pkg::PH_SAVING,
		"record outside saving phase")
	`DCSS_ASSERT_NOW(a_supply_follows_phase,
		!out_valid || (supply_on == (phase != dcss_pkg::PH_SLEEP)),
		"supply does not match phase")
	`DCSS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
		"ready held during tick processing")

endmodule

FILE: sim/duty_cycled_sensor_sampler_unit_tb.sv
// Self-checking bench for duty_cycled_sensor_sampler_unit: sends millisecond ticks,
// predicts every per-tick result in-bench and compares the outputs field by field.
// Depends on dcss_pkg and the RTL of duty_cycled_sensor_sampler_unit.
module duty_cycled_sensor_sampler_unit_tb;

	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int DRAIN_CYCLES    = 40;

	typedef struct packed {
		dcss_pkg::phase_t                phase;
		logic                            supply_on;
		logic                            record_valid;
		logic                            record_alarm;
		logic                            record_error;
		logic [dcss_pkg::AVG_BITS-1:0]   record_average;
		logic                            error_flag;
	} tick_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [dcss_pkg::ADC_BITS_DEF-1:0] adc_sample = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] phase;
	logic supply_on, record_valid, record_alarm, record_error, error_flag;
	logic [dcss_pkg::AVG_BITS-1:0] record_average;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [dcss_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [dcss_pkg::CFG_BITS-1:0] cfg_data = '0;

	// sampler state as predicted
	dcss_pkg::phase_t st_phase;
	logic [31:0]   tick_cnt, acc_sum;
	logic [15:0]   acc_count, avg_held;
	logic [7:0]    warn_cnt;
	logic [31:0]   dl_sleep, dl_setup, dl_measure, dl_warning;
	logic          alarm_held, err_held, pwr_held;
	logic [15:0]   cfg_thr_low, cfg_thr_high, cfg_thr_max, cfg_setup;
	logic [15:0]   cfg_warning, cfg_sleep, cfg_measure, cfg_samples;

	tick_result_t  expected_q[$];
	int            n_fail = 0;
	int            quiet_cycles = 0;
	int            hold_left = 0;
	logic          hold_req = 1'b0;
	logic          idle_on = 1'b0;
	logic          record_seen;

	duty_cycled_sensor_sampler_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .adc_sample(adc_sample),
		.out_valid(out_valid), .out_ready(out_ready), .phase(phase),
		.supply_on(supply_on), .record_valid(record_valid), .record_alarm(record_alarm),
		.record_error(record_error), .record_average(record_average),
		.error_flag(error_flag),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [dcss_pkg::ADC_BITS_DEF-1:0] rand_adc();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return '0;
		if (r == 1) return '1;
		return dcss_pkg::ADC_BITS_DEF'($urandom_range(0, 4095));
	endfunction

	function automatic logic [15:0] rand_threshold();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0) return 16'd0;
		if (r == 1) return 16'hFFFF;
		if (r == 2) return 16'($urandom_range(0, 65535));
		return 16'($urandom_range(0, 4095));
	endfunction

	function automatic logic [15:0] rand_period();
		return ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 5));
	endfunction

	function automatic void add_sample(input logic [dcss_pkg::ADC_BITS_DEF-1:0] adc);
		logic [32:0] total;
		total = {1'b0, acc_sum} + {21'd0, adc};
		acc_sum = total[32] ? 32'hFFFF_FFFF : total[31:0];
		if (acc_count != 16'hFFFF) acc_count = acc_count + 16'd1;
		dl_measure = tick_cnt + {16'd0, cfg_measure};
	endfunction

	// Advance the predicted sampler by one tick and return what it shows.
	function automatic tick_result_t step_sampler(
			input logic [dcss_pkg::ADC_BITS_DEF-1:0] adc);
		tick_result_t r;
		logic saved;
		logic [31:0] quot;
		saved = 1'b0;
		case (st_phase)
			dcss_pkg::PH_SLEEP: begin
				if (tick_cnt > dl_sleep) begin
					acc_count = '0;
					warn_cnt = '0;
					acc_sum = '0;
					avg_held = '0;
					err_held = 1'b0;
					dl_setup = tick_cnt + {16'd0, cfg_setup};
					pwr_held = 1'b1;
					st_phase = dcss_pkg::PH_SETUP;
				end
			end
			dcss_pkg::PH_SETUP: begin
				if (tick_cnt > dl_setup) begin
					add_sample(adc);
					st_phase = dcss_pkg::PH_MEASURE;
				end
			end
			dcss_pkg::PH_MEASURE: begin
				if (tick_cnt > dl_measure) begin
					add_sample(adc);
				end else if (acc_count >= cfg_samples) begin
					quot = (acc_count != 16'd0) ? acc_sum / {16'd0, acc_count} : 32'd0;
					avg_held = (quot > 32'h0000_FFFF) ? 16'hFFFF : quot[15:0];
					alarm_held = !(avg_held <= cfg_thr_high && avg_held >= cfg_thr_low);
					st_phase = dcss_pkg::PH_PROCESS;
				end
			end
			dcss_pkg::PH_PROCESS: begin
				if (avg_held == 16'd0 || avg_held > cfg_thr_max) begin
					if (warn_cnt != 8'hFF) warn_cnt = warn_cnt + 8'd1;
					dl_warning = tick_cnt + {16'd0, cfg_warning};
					st_phase = dcss_pkg::PH_WARNING;
				end else begin
					saved = 1'b1;
					st_phase = dcss_pkg::PH_SAVING;
				end
			end
			dcss_pkg::PH_WARNING: begin
				if (tick_cnt > dl_warning) begin
					add_sample(adc);
					st_phase = dcss_pkg::PH_MEASURE;
				end else if (warn_cnt >= dcss_pkg::WARN_LIMIT) begin
					saved = 1'b1;
					st_phase = dcss_pkg::PH_SAVING;
				end
			end
			dcss_pkg::PH_SAVING: begin
				dl_sleep = tick_cnt + {16'd0, cfg_sleep};
				pwr_held = 1'b0;
				if (warn_cnt >= dcss_pkg::WARN_LIMIT) err_held = 1'b1;
				st_phase = dcss_pkg::PH_SLEEP;
			end
			default: st_phase = dcss_pkg::PH_SLEEP;
		endcase
		r.phase = st_phase;
		r.supply_on = pwr_held;
		r.record_valid = saved;
		r.record_alarm = saved & alarm_held;
		r.record_error = saved & err_held;
		r.record_average = saved ? avg_held : '0;
		r.error_flag = err_held;
		tick_cnt = tick_cnt + 32'd1;
		return r;
	endfunction

	// Offer one tick, hold it until accepted and log its expected result.
	task automatic send_tick(input logic [dcss_pkg::ADC_BITS_DEF-1:0] value);
		int gap;
		tick_result_t r;
		gap = idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		adc_sample = value;
		@(posedge clk);
		while (in_ready !== 1'b1) @(posedge clk);
		r = step_sampler(value);
		expected_q.push_back(r);
		record_seen = r.record_valid;
		@(negedge clk);
	endtask

	task automatic send_until_record(input int value, input int max_ticks);
		int n;
		n = 0;
		record_seen = 1'b0;
		while (!record_seen && n < max_ticks) begin
			send_tick((value < 0) ? rand_adc() : value[dcss_pkg::ADC_BITS_DEF-1:0]);
			n++;
		end
	endtask

	task automatic settle();
		in_valid = 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
	endtask

	// Write one register once every expected result has come back.
	task automatic write_reg(input logic [dcss_pkg::CFG_IDX_BITS-1:0] idx,
			input logic [15:0] value);
		settle();
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(posedge clk);
		while (cfg_ready !== 1'b1) @(posedge clk);
		case (idx)
			dcss_pkg::REG_THR_LOW:  cfg_thr_low = value;
			dcss_pkg::REG_THR_HIGH: cfg_thr_high = value;
			dcss_pkg::REG_THR_MAX:  cfg_thr_max = value;
			dcss_pkg::REG_SETUP:    cfg_setup = value;
			dcss_pkg::REG_WARNING:  cfg_warning = value;
			dcss_pkg::REG_SLEEP:    cfg_sleep = value;
			dcss_pkg::REG_MEASURE:  cfg_measure = value;
			dcss_pkg::REG_SAMPLES:  cfg_samples = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic test_reset_defaults();
		send_tick('0);
		send_tick('1);
		send_tick(12'hAAA);
		send_tick(12'h555);
	endtask

	task automatic test_records_and_alarms();
		write_reg(dcss_pkg::REG_THR_LOW, 16'd100);
		write_reg(dcss_pkg::REG_THR_HIGH, 16'd200);
		write_reg(dcss_pkg::REG_THR_MAX, 16'd4095);
		write_reg(dcss_pkg::REG_SETUP, 16'd0);
		write_reg(dcss_pkg::REG_WARNING, 16'd1);
		write_reg(dcss_pkg::REG_SLEEP, 16'd0);
		write_reg(dcss_pkg::REG_MEASURE, 16'd1);
		write_reg(dcss_pkg::REG_SAMPLES, 16'd1);
		send_until_record(50, 50);
		send_until_record(150, 50);
		send_until_record(4095, 50);
	endtask

	task automatic test_warnings_and_error();
		// zero average: warn, resample, warn again, then save
		send_until_record(0, 50);
		write_reg(dcss_pkg::REG_THR_MAX, 16'd1000);
		send_until_record(3000, 50);
		send_tick(12'd500);
	endtask

	task automatic test_warning_count_saturation();
		write_reg(dcss_pkg::REG_THR_MAX, 16'd0);
		write_reg(dcss_pkg::REG_WARNING, 16'd0);
		write_reg(dcss_pkg::REG_MEASURE, 16'd1);
		write_reg(dcss_pkg::REG_SAMPLES, 16'd1);
		repeat (820) send_tick(rand_adc());
		write_reg(dcss_pkg::REG_WARNING, 16'hFFFF);
		send_until_record(-1, 20);
		send_tick(rand_adc());
	endtask

	task automatic test_back_pressure();
		idle_on = 1'b0;
		write_reg(dcss_pkg::REG_THR_LOW, 16'd0);
		write_reg(dcss_pkg::REG_THR_HIGH, 16'd4095);
		write_reg(dcss_pkg::REG_THR_MAX, 16'd4095);
		write_reg(dcss_pkg::REG_SETUP, 16'd1);
		write_reg(dcss_pkg::REG_WARNING, 16'd2);
		write_reg(dcss_pkg::REG_SLEEP, 16'd1);
		write_reg(dcss_pkg::REG_MEASURE, 16'd1);
		write_reg(dcss_pkg::REG_SAMPLES, 16'd2);
		@(posedge clk);
		hold_req = 1'b1;
		@(negedge clk);
		repeat (40) send_tick(rand_adc());
	endtask

	task automatic test_random_cycles();
		int p, k;
		for (p = 0; p < 8; p++) begin
			write_reg(dcss_pkg::REG_THR_LOW, rand_threshold());
			write_reg(dcss_pkg::REG_THR_HIGH, rand_threshold());
			write_reg(dcss_pkg::REG_THR_MAX, rand_threshold());
			write_reg(dcss_pkg::REG_SETUP, rand_period());
			write_reg(dcss_pkg::REG_WARNING, rand_period());
			write_reg(dcss_pkg::REG_SLEEP, rand_period());
			// a zero measure period traps the block in measure, so keep it rare
			write_reg(dcss_pkg::REG_MEASURE,
				(p == 5) ? 16'd0 : 16'($urandom_range(1, 5)));
			write_reg(dcss_pkg::REG_SAMPLES, 16'($urandom_range(0, 4)));
			for (k = 0; k < 50; k++) begin
				if (k % 25 == 0) idle_on = ($urandom_range(0, 3) != 0);
				send_tick(rand_adc());
			end
		end
	endtask

	initial begin
		cfg_thr_low = dcss_pkg::RST_THR_LOW;
		cfg_thr_high = dcss_pkg::RST_THR_HIGH;
		cfg_thr_max = dcss_pkg::RST_THR_MAX;
		cfg_setup = dcss_pkg::RST_PERIOD;
		cfg_warning = dcss_pkg::RST_PERIOD;
		cfg_sleep = dcss_pkg::RST_PERIOD;
		cfg_measure = dcss_pkg::RST_PERIOD;
		cfg_samples = dcss_pkg::RST_SAMPLES;
		st_phase = dcss_pkg::PH_SLEEP;
		tick_cnt = '0;
		acc_sum = '0;
		acc_count = '0;
		avg_held = '0;
		warn_cnt = '0;
		dl_sleep = '0;
		dl_setup = '0;
		dl_measure = '0;
		dl_warning = '0;
		alarm_held = 1'b0;
		err_held = 1'b0;
		pwr_held = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		idle_on = 1'b1;
		test_reset_defaults();
		test_records_and_alarms();
		test_warnings_and_error();
		idle_on = 1'b1;
		test_warning_count_saturation();
		test_back_pressure();
		test_random_cycles();
		settle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (n_fail == 0) begin
			$display("PASS duty_cycled_sensor_sampler_unit");
		end else begin
			$display("FAIL duty_cycled_sensor_sampler_unit");
		end
		$finish;
	end

	// Result side: random stalls, plus one long hold-off on request.
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_OFF_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			out_ready = 1'b0;
			hold_left--;
		end else if (idle_on && $urandom_range(0, 3) == 0) begin
			out_ready = 1'b0;
			hold_left = pick_gap();
		end else begin
			out_ready = 1'b1;
		end
	end

	always @(posedge clk) begin : check_results
		tick_result_t exp_r;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (expected_q.size() == 0) begin
				$error("result transaction with no tick pending");
				n_fail++;
			end else begin
				exp_r = expected_q.pop_front();
				if (phase !== exp_r.phase) begin
					$error("phase: expected %0d, actual %0d", exp_r.phase, phase);
					n_fail++;
				end
				if (supply_on !== exp_r.supply_on) begin
					$error("supply_on: expected %0d, actual %0d", exp_r.supply_on, supply_on);
					n_fail++;
				end
				if (record_valid !== exp_r.record_valid) begin
					$error("record_valid: expected %0d, actual %0d",
						exp_r.record_valid, record_valid);
					n_fail++;
				end
				if (record_alarm !== exp_r.record_alarm) begin
					$error("record_alarm: expected %0d, actual %0d",
						exp_r.record_alarm, record_alarm);
					n_fail++;
				end
				if (record_error !== exp_r.record_error) begin
					$error("record_error: expected %0d, actual %0d",
						exp_r.record_error, record_error);
					n_fail++;
				end
				if (record_average !== exp_r.record_average) begin
					$error("record_average: expected %0d, actual %0d",
						exp_r.record_average, record_average);
					n_fail++;
				end
				if (error_flag !== exp_r.error_flag) begin
					$error("error_flag: expected %0d, actual %0d", exp_r.error_flag, error_flag);
					n_fail++;
				end
			end
		end
	end

	// Drop the run when no transaction of any kind has moved for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)
				|| (cfg_valid && cfg_ready === 1'b1)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL duty_cycled_sensor_sampler_unit");
			$finish;
		end
	end

endmodule
